// ===== rtl/core/assert_macros.svh =====
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CBPA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define CBPA_ASSERT_NEVER(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("forbidden condition seen");

`else

`define CBPA_ASSERT(label, clk, rst_n, prop)

`define CBPA_ASSERT_NEVER(label, clk, rst_n, prop)

`endif

`endif

// ===== rtl/core/cbpa_pkg.sv =====
package cbpa_pkg;

    localparam int ADDR_W       = 32;
    localparam int SHIFT_W      = 5;
    localparam int CFG_CNT_W    = 11;
    localparam int INDEX_W      = 10;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int MAX_SHIFT    = 16;
    localparam int PROD_W       = 2 * CFG_CNT_W;
    localparam int DEF_CAPACITY = 1024;

    localparam logic [ADDR_W-1:0]    RST_POOL_BASE = 32'h0000_0000;
    localparam logic [SHIFT_W-1:0]   RST_ELEM_LOG2 = 5'd6;
    localparam logic [CFG_CNT_W-1:0] RST_PER_CHUNK = 11'd64;
    localparam logic [CFG_CNT_W-1:0] RST_MAX_ELEM  = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_LOG2  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PER_CHUNK  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ELEM   = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_INVALID   = 2'd2
    } t_status;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_POP   = 4'b0100,
        S_CHECK = 4'b1000
    } t_state;

    typedef struct packed {
        logic open_chunk;
        logic exhausted;
    } t_fresh_dec;

    typedef struct packed {
        logic unaligned;
        logic out_of_range;
    } t_free_chk;

endpackage

// ===== rtl/core/cbpa_ram.sv =====
module cbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/cbpa_fresh.sv =====
module cbpa_fresh import cbpa_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic [CFG_CNT_W-1:0] i_chunks_opened,
    input  logic [CFG_CNT_W-1:0] i_per_chunk,
    input  logic [CFG_CNT_W-1:0] i_max_elements,
    input  logic [CNT_W-1:0]     i_fresh_count,
    output t_fresh_dec           o_dec
);

    localparam int LIM_W = PROD_W + 1;

    logic [CFG_CNT_W-1:0] pc;
    logic [PROD_W-1:0]    prod;
    logic [LIM_W-1:0]     prod_ext;
    logic [LIM_W-1:0]     prod_next;
    logic [LIM_W-1:0]     cap_ext;
    logic [LIM_W-1:0]     lim_now;
    logic [LIM_W-1:0]     lim_next;
    logic [LIM_W-1:0]     fresh_ext;
    logic                 can_open;
    logic                 need;

    assign pc        = (i_per_chunk == '0) ? CFG_CNT_W'(1) : i_per_chunk;
    assign prod      = PROD_W'(i_chunks_opened) * PROD_W'(pc);
    assign prod_ext  = LIM_W'(prod);
    assign prod_next = prod_ext + LIM_W'(pc);
    assign cap_ext   = LIM_W'(CAPACITY);
    assign fresh_ext = LIM_W'(i_fresh_count);
    assign lim_now   = (prod_ext > cap_ext) ? cap_ext : prod_ext;
    assign lim_next  = (prod_next > cap_ext) ? cap_ext : prod_next;

    // chunks < ceil(max / pc) is the same as chunks * pc < max
    assign can_open  = prod_ext < LIM_W'(i_max_elements);
    assign need      = fresh_ext >= lim_now;

    assign o_dec.open_chunk = need && can_open;
    assign o_dec.exhausted  = need && (can_open ? (fresh_ext >= lim_next) : 1'b1);

endmodule

// ===== rtl/core/cbpa_addr.sv =====
module cbpa_addr import cbpa_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int IDX_W    = $clog2(CAPACITY)
) (
    input  logic [ADDR_W-1:0]  i_pool_base,
    input  logic [SHIFT_W-1:0] i_elem_log2,
    input  logic [ADDR_W-1:0]  i_free_address,
    input  logic [IDX_W-1:0]   i_alloc_idx,
    output logic [IDX_W-1:0]   o_free_idx,
    output t_free_chk          o_chk,
    output logic [ADDR_W-1:0]  o_alloc_address
);

    logic [SHIFT_W-1:0] sh;
    logic [ADDR_W-1:0]  off;
    logic [ADDR_W-1:0]  low_mask;
    logic [ADDR_W-1:0]  idx_full;

    assign sh       = (i_elem_log2 > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : i_elem_log2;
    assign off      = i_free_address - i_pool_base;
    assign low_mask = (ADDR_W'(1) << sh) - ADDR_W'(1);
    assign idx_full = off >> sh;

    assign o_chk.unaligned    = |(off & low_mask);
    assign o_chk.out_of_range = idx_full >= ADDR_W'(CAPACITY);
    assign o_free_idx         = idx_full[IDX_W-1:0];
    assign o_alloc_address    = i_pool_base + (ADDR_W'(i_alloc_idx) << sh);

endmodule

// ===== rtl/core/chunked_buffer_pool_allocator_core.sv =====
// Fixed-size buffer pool allocator.
// Command channel: an item (i_command, i_free_address) is taken at a clock
// edge where start is high and busy is low. Allocate returns the most recently
// freed buffer, else the next fresh buffer, opening a new chunk on demand.
// Free checks alignment, range and the in-use map, then pushes the index.
// Result channel: o_valid is high for exactly one cycle with o_status,
// o_buffer_address and o_element_index; the receiver cannot stall it.
// A fresh allocate, an exhausted allocate and a free with a bad address
// are answered from S_IDLE; a pop from the freed stack or a free that needs
// the in-use lookup first waits in S_POP or S_CHECK for the registered read
// of that memory, with busy high, so no new item is taken there.
// Reset: configuration takes its defaults, counters clear, and the in-use
// memory is swept to zero, one entry per cycle, over all CAPACITY entries
// while busy stays high. Configuration writes are taken at any time, but
// change behavior correctly only while no item is in flight.
`include "assert_macros.svh"

module chunked_buffer_pool_allocator_core import cbpa_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_command,
    input  logic [ADDR_W-1:0]     i_free_address,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                  o_valid,
    output logic [STATUS_W-1:0]   o_status,
    output logic [ADDR_W-1:0]     o_buffer_address,
    output logic [INDEX_W-1:0]    o_element_index
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [ADDR_W-1:0]    r_pool_base;
    logic [SHIFT_W-1:0]   r_elem_log2;
    logic [CFG_CNT_W-1:0] r_per_chunk;
    logic [CFG_CNT_W-1:0] r_max_elements;

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_clr_addr, n_clr_addr;
    logic [CNT_W-1:0]     r_freed_count, n_freed_count;
    logic [CNT_W-1:0]     r_fresh_count, n_fresh_count;
    logic [CFG_CNT_W-1:0] r_chunks, n_chunks;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_valid, n_valid;
    t_status              r_status, n_status;
    logic [IDX_W-1:0]     r_out_idx, n_out_idx;
    logic [ADDR_W-1:0]    r_out_addr, n_out_addr;

    logic                 accept;
    logic [CNT_W-1:0]     pop_count;
    logic [IDX_W-1:0]     alloc_idx;
    logic [IDX_W-1:0]     free_idx;
    logic [ADDR_W-1:0]    alloc_address;
    t_free_chk            free_chk;
    t_fresh_dec           fresh_dec;

    logic                 map_we;
    logic [IDX_W-1:0]     map_waddr;
    logic [0:0]           map_wdata;
    logic [0:0]           map_rdata;
    logic                 stack_we;
    logic [IDX_W-1:0]     stack_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base    <= RST_POOL_BASE;
            r_elem_log2    <= RST_ELEM_LOG2;
            r_per_chunk    <= RST_PER_CHUNK;
            r_max_elements <= RST_MAX_ELEM;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POOL_BASE: r_pool_base    <= i_cfg_wdata[ADDR_W-1:0];
                CFG_ELEM_LOG2: r_elem_log2    <= i_cfg_wdata[SHIFT_W-1:0];
                CFG_PER_CHUNK: r_per_chunk    <= i_cfg_wdata[CFG_CNT_W-1:0];
                CFG_MAX_ELEM:  r_max_elements <= i_cfg_wdata[CFG_CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign pop_count = r_freed_count - CNT_W'(1);
    assign alloc_idx = (r_state == S_POP) ? stack_rdata : r_fresh_count[IDX_W-1:0];

    cbpa_fresh #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_fresh (
        .i_chunks_opened (r_chunks),
        .i_per_chunk     (r_per_chunk),
        .i_max_elements  (r_max_elements),
        .i_fresh_count   (r_fresh_count),
        .o_dec           (fresh_dec)
    );

    cbpa_addr #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_addr (
        .i_pool_base     (r_pool_base),
        .i_elem_log2     (r_elem_log2),
        .i_free_address  (i_free_address),
        .i_alloc_idx     (alloc_idx),
        .o_free_idx      (free_idx),
        .o_chk           (free_chk),
        .o_alloc_address (alloc_address)
    );

    cbpa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CAPACITY)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stack_we),
        .i_waddr (r_freed_count[IDX_W-1:0]),
        .i_wdata (r_idx),
        .i_raddr (pop_count[IDX_W-1:0]),
        .o_rdata (stack_rdata)
    );

    cbpa_ram #(
        .WIDTH (1),
        .DEPTH (CAPACITY)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (free_idx),
        .o_rdata (map_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_freed_count = r_freed_count;
        n_fresh_count = r_fresh_count;
        n_chunks      = r_chunks;
        n_idx         = r_idx;
        n_valid       = 1'b0;
        n_status      = ST_OK;
        n_out_idx     = '0;
        n_out_addr    = '0;
        map_we        = 1'b0;
        map_waddr     = alloc_idx;
        map_wdata     = 1'b1;
        stack_we      = 1'b0;

        case (r_state)
            S_CLEAR: begin
                map_we     = 1'b1;
                map_waddr  = r_clr_addr;
                map_wdata  = 1'b0;
                n_clr_addr = r_clr_addr + IDX_W'(1);
                if (r_clr_addr == IDX_W'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_ALLOC) begin
                        if (r_freed_count != '0) begin
                            n_freed_count = pop_count;
                            n_state       = S_POP;
                        end else begin
                            if (fresh_dec.open_chunk) begin
                                n_chunks = r_chunks + CFG_CNT_W'(1);
                            end
                            n_valid = 1'b1;
                            if (fresh_dec.exhausted) begin
                                n_status = ST_EXHAUSTED;
                            end else begin
                                map_we        = 1'b1;
                                n_fresh_count = r_fresh_count + CNT_W'(1);
                                n_out_idx     = alloc_idx;
                                n_out_addr    = alloc_address;
                            end
                        end
                    end else begin
                        if (free_chk.unaligned || free_chk.out_of_range) begin
                            n_valid  = 1'b1;
                            n_status = ST_INVALID;
                        end else begin
                            n_idx   = free_idx;
                            n_state = S_CHECK;
                        end
                    end
                end
            end
            S_POP: begin
                map_we     = 1'b1;
                n_valid    = 1'b1;
                n_out_idx  = alloc_idx;
                n_out_addr = alloc_address;
                n_state    = S_IDLE;
            end
            S_CHECK: begin
                n_valid = 1'b1;
                if (map_rdata[0]) begin
                    map_we    = 1'b1;
                    map_waddr = r_idx;
                    map_wdata = 1'b0;
                    stack_we  = 1'b1;
                    n_out_idx = r_idx;
                    if (r_freed_count < CNT_W'(CAPACITY)) begin
                        n_freed_count = r_freed_count + CNT_W'(1);
                    end
                end else begin
                    n_status = ST_INVALID;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_addr    <= '0;
            r_freed_count <= '0;
            r_fresh_count <= '0;
            r_chunks      <= '0;
            r_valid       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr_addr    <= n_clr_addr;
            r_freed_count <= n_freed_count;
            r_fresh_count <= n_fresh_count;
            r_chunks      <= n_chunks;
            r_valid       <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_status   <= n_status;
        r_out_idx  <= n_out_idx;
        r_out_addr <= n_out_addr;
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_buffer_address = r_out_addr;
    assign o_element_index  = INDEX_W'(r_out_idx);

    `CBPA_ASSERT(a_freed_bound, i_clk, i_rst_n, r_freed_count <= CNT_W'(CAPACITY))
    `CBPA_ASSERT(a_second_cycle_done, i_clk, i_rst_n, (r_state == S_POP || r_state == S_CHECK) |=> o_valid)
    `CBPA_ASSERT(a_fail_zero, i_clk, i_rst_n, (o_valid && o_status != ST_OK) |-> (o_buffer_address == '0 && o_element_index == '0))
    `CBPA_ASSERT_NEVER(a_clear_quiet, i_clk, i_rst_n, r_state == S_CLEAR && o_valid)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import cbpa_pkg::*;

    localparam int CAP         = DEF_CAPACITY;
    localparam int STALL_LIMIT = 5 * CAP;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_status             st;
        logic [ADDR_W-1:0]   addr;
        logic [INDEX_W-1:0]  idx;
    } t_pool_result;

    typedef struct packed {
        t_row_kind              kind;
        t_cmd                   cmd;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   typed;
        t_pool_result           want;
    } t_dir_row;

    localparam t_dir_row DIRECTED [29] = '{
        '{ROW_ITEM, CMD_ALLOC, CFG_POOL_BASE, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0000_0000, 10'd0}},
        '{ROW_ITEM, CMD_ALLOC, CFG_POOL_BASE, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0000_0040, 10'd1}},
        '{ROW_ITEM, CMD_FREE,  CFG_POOL_BASE, 32'h0000_0040, 1'b1, '{ST_OK, 32'h0000_0000, 10'd1}},
        '{ROW_ITEM, CMD_FREE,  CFG_POOL_BASE, 32'h0000_0040, 1'b1, '{ST_INVALID, 32'h0, 10'd0}},
        '{ROW_ITEM, CMD_FREE,  CFG_POOL_BASE, 32'h0000_0041, 1'b1, '{ST_INVALID, 32'h0, 10'd0}},
        '{ROW_ITEM, CMD_FREE,  CFG_POOL_BASE, 32'h0001_0000, 1'b1, '{ST_INVALID, 32'h0, 10'd0}},
        '{ROW_ITEM, CMD_FREE,  CFG_POOL_BASE, 32'hFFFF_FFC0, 1'b1, '{ST_INVALID, 32'h0, 10'd0}},
        '{ROW_ITEM, CMD_ALLOC, CFG_POOL_BASE, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0000_0040, 10'd1}},
        '{ROW_CFG,  CMD_ALLOC, CFG_POOL_BASE, 32'hFFFF_0000, 1'b0, '{ST_OK, 32'h0, 10'd0}},
        '{ROW_CFG,  CMD_ALLOC, CFG_ELEM_LOG2, 32'd31,        1'b0, '{ST_OK, 32'h0, 10'd0}},
        '{ROW_ITEM, CMD_ALLOC, CFG_POOL_BASE, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0001_0000, 10'd2}},
        '{ROW_ITEM, CMD_FREE,  CFG_POOL_BASE, 32'h0001_8000, 1'b1, '{ST_INVALID, 32'h0, 10'd0}},
        '{ROW_ITEM, CMD_FREE,  CFG_POOL_BASE, 32'h0001_0000, 1'b1, '{ST_OK, 32'h0000_0000, 10'd2}},
        '{ROW_CFG,  CMD_ALLOC, CFG_POOL_BASE, 32'h0000_0000, 1'b0, '{ST_OK, 32'h0, 10'd0}},
        '{ROW_CFG,  CMD_ALLOC, CFG_ELEM_LOG2, 32'd0,         1'b0, '{ST_OK, 32'h0, 10'd0}},
        '{ROW_ITEM, CMD_FREE,  CFG_POOL_BASE, 32'h0000_0400, 1'b1, '{ST_INVALID, 32'h0, 10'd0}},
        '{ROW_ITEM, CMD_FREE,  CFG_POOL_BASE, 32'h0000_03FF, 1'b1, '{ST_INVALID, 32'h0, 10'd0}},
        '{ROW_CFG,  CMD_ALLOC, CFG_PER_CHUNK, 32'd0,         1'b0, '{ST_OK, 32'h0, 10'd0}},
        '{ROW_CFG,  CMD_ALLOC, CFG_MAX_ELEM,  32'd0,         1'b0, '{ST_OK, 32'h0, 10'd0}},
        '{ROW_ITEM, CMD_ALLOC, CFG_POOL_BASE, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0000_0002, 10'd2}},
        '{ROW_ITEM, CMD_ALLOC, CFG_POOL_BASE, 32'h0000_0000, 1'b1, '{ST_EXHAUSTED, 32'h0, 10'd0}},
        '{ROW_CFG,  CMD_ALLOC, CFG_MAX_ELEM,  32'd2047,      1'b0, '{ST_OK, 32'h0, 10'd0}},
        '{ROW_ITEM, CMD_ALLOC, CFG_POOL_BASE, 32'h0000_0000, 1'b1, '{ST_EXHAUSTED, 32'h0, 10'd0}},
        '{ROW_ITEM, CMD_ALLOC, CFG_POOL_BASE, 32'h0000_0000, 1'b1, '{ST_EXHAUSTED, 32'h0, 10'd0}},
        '{ROW_ITEM, CMD_ALLOC, CFG_POOL_BASE, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0000_0003, 10'd3}},
        '{ROW_CFG,  CMD_ALLOC, CFG_PER_CHUNK, 32'd2047,      1'b0, '{ST_OK, 32'h0, 10'd0}},
        '{ROW_ITEM, CMD_ALLOC, CFG_POOL_BASE, 32'h0000_0000, 1'b1, '{ST_OK, 32'h0000_0004, 10'd4}},
        '{ROW_ITEM, CMD_FREE,  CFG_POOL_BASE, 32'hFFFF_FFFF, 1'b1, '{ST_INVALID, 32'h0, 10'd0}},
        '{ROW_ITEM, CMD_FREE,  CFG_POOL_BASE, 32'h0000_0004, 1'b0, '{ST_OK, 32'h0, 10'd0}}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic                   i_command;
    logic [ADDR_W-1:0]      i_free_address;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                   o_valid;
    logic [STATUS_W-1:0]    o_status;
    logic [ADDR_W-1:0]      o_buffer_address;
    logic [INDEX_W-1:0]     o_element_index;

    chunked_buffer_pool_allocator_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_free_address   (i_free_address),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_buffer_address (o_buffer_address),
        .o_element_index  (o_element_index)
    );

    logic [ADDR_W-1:0]     cfg_pool_base = RST_POOL_BASE;
    logic [SHIFT_W-1:0]    cfg_elem_log2 = RST_ELEM_LOG2;
    logic [CFG_CNT_W-1:0]  cfg_per_chunk = RST_PER_CHUNK;
    logic [CFG_CNT_W-1:0]  cfg_max_elem  = RST_MAX_ELEM;

    logic [INDEX_W-1:0]    freed_stack [CAP];
    bit                    in_use [CAP];
    int                    freed_count   = 0;
    int                    fresh_count   = 0;
    int                    chunks_opened = 0;
    int                    n_in_use      = 0;

    t_pool_result          pending_results [$];
    bit                    idle_on = 1'b1;
    int                    quiet_cycles = 0;
    int                    n_items = 0;
    int                    n_reg_writes = 0;
    int                    n_checked = 0;
    int                    n_ok = 0;
    int                    n_exhausted = 0;
    int                    n_invalid = 0;
    int                    n_errors = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int elem_shift();
        return (cfg_elem_log2 > 5'd16) ? 16 : int'(cfg_elem_log2);
    endfunction

    function automatic int fresh_ceiling(int per_chunk);
        int lim;
        lim = chunks_opened * per_chunk;
        return (lim > CAP) ? CAP : lim;
    endfunction

    function automatic t_pool_result alloc_free_outcome(t_cmd cmd, logic [ADDR_W-1:0] addr);
        t_pool_result r;
        int sh;
        int per_chunk;
        int chunk_cap;
        int slot;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] idx32;
        sh = elem_shift();
        per_chunk = (cfg_per_chunk == '0) ? 1 : int'(cfg_per_chunk);
        r = '{ST_OK, 32'h0, 10'd0};
        if (cmd == CMD_ALLOC) begin
            if (freed_count > 0) begin
                freed_count--;
                slot = int'(freed_stack[freed_count]);
            end else begin
                if (fresh_count >= fresh_ceiling(per_chunk)) begin
                    chunk_cap = (int'(cfg_max_elem) + per_chunk - 1) / per_chunk;
                    if (chunks_opened < chunk_cap)
                        chunks_opened++;
                end
                if (fresh_count >= fresh_ceiling(per_chunk)) begin
                    r.st = ST_EXHAUSTED;
                    return r;
                end
                slot = fresh_count;
                fresh_count++;
            end
            in_use[slot] = 1'b1;
            n_in_use++;
            r.addr = cfg_pool_base + (32'(slot) << sh);
            r.idx = INDEX_W'(slot);
        end else begin
            off = addr - cfg_pool_base;
            idx32 = off >> sh;
            if ((off & ((32'd1 << sh) - 32'd1)) != 0 || idx32 >= CAP
                    || !in_use[idx32[INDEX_W-1:0]]) begin
                r.st = ST_INVALID;
            end else begin
                in_use[idx32[INDEX_W-1:0]] = 1'b0;
                n_in_use--;
                freed_stack[freed_count] = idx32[INDEX_W-1:0];
                freed_count++;
                r.idx = idx32[INDEX_W-1:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_errors < 100)
            $display("MISMATCH %s at result %0d: got %h, expected %h",
                     what, n_checked, got, want);
        n_errors++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_POOL_BASE: cfg_pool_base = data;
            CFG_ELEM_LOG2: cfg_elem_log2 = data[SHIFT_W-1:0];
            CFG_PER_CHUNK: cfg_per_chunk = data[CFG_CNT_W-1:0];
            CFG_MAX_ELEM:  cfg_max_elem  = data[CFG_CNT_W-1:0];
            default: ;
        endcase
        n_reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic settle_pool();
        start    <= 1'b0;
        i_cfg_we <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_item(input t_cmd cmd, input logic [ADDR_W-1:0] addr, input logic typed,
                             input t_pool_result want, output t_pool_result predicted);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 11);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_command      <= cmd;
        i_free_address <= addr;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        predicted = alloc_free_outcome(cmd, addr);
        pending_results.push_back(typed ? want : predicted);
        n_items++;
    endtask

    task automatic pick_request(output t_cmd cmd, output logic [ADDR_W-1:0] addr);
        int sh;
        int slot;
        int k;
        int pick;
        sh = elem_shift();
        cmd = CMD_FREE;
        addr = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            cmd = CMD_ALLOC;
        end else if (pick < 85 && n_in_use > 0) begin
            slot = $urandom_range(0, CAP - 1);
            for (k = 0; k < CAP && !in_use[slot]; k++)
                slot = (slot + 1) % CAP;
            addr = cfg_pool_base + (32'(slot) << sh);
        end else if (pick < 90) begin
            addr = cfg_pool_base + (32'($urandom_range(0, CAP - 1)) << sh);
        end else if (pick < 95) begin
            if (sh > 0)
                addr = cfg_pool_base + (32'($urandom_range(0, CAP - 1)) << sh)
                       + $urandom_range(1, (1 << sh) - 1);
            else
                addr = cfg_pool_base + CAP + $urandom_range(0, 4095);
        end else if (pick < 97) begin
            addr = cfg_pool_base + ((32'(CAP) + $urandom_range(0, 63)) << sh);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_pool_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no item pending", 32'(o_status), 32'h0);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_status !== want.st)
                    report_mismatch("status", 32'(o_status), 32'(want.st));
                if (o_buffer_address !== want.addr)
                    report_mismatch("buffer_address", o_buffer_address, want.addr);
                if (o_element_index !== want.idx)
                    report_mismatch("element_index", 32'(o_element_index), 32'(want.idx));
                case (want.st)
                    ST_OK:        n_ok++;
                    ST_EXHAUSTED: n_exhausted++;
                    default:      n_invalid++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: %0d cycles without progress, %0d results pending",
                     quiet_cycles, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_cmd cmd;
        logic [ADDR_W-1:0] addr;
        t_pool_result pred;
        bit cfg_run;
        bit full;
        int ph;
        int k;
        start          <= 1'b0;
        i_command      <= CMD_ALLOC;
        i_free_address <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= CFG_POOL_BASE;
        i_cfg_wdata    <= '0;
        i_rst_n        <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cfg_run = 1'b0;
        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                if (!cfg_run)
                    settle_pool();
                write_reg(DIRECTED[r].reg_idx, DIRECTED[r].data);
                cfg_run = 1'b1;
            end else begin
                if (cfg_run)
                    i_cfg_we <= 1'b0;
                cfg_run = 1'b0;
                send_item(DIRECTED[r].cmd, DIRECTED[r].data, DIRECTED[r].typed,
                          DIRECTED[r].want, pred);
            end
        end

        for (ph = 0; ph < 6; ph++) begin
            settle_pool();
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_POOL_BASE, 32'h0000_0000);
                1:       write_reg(CFG_POOL_BASE, 32'hFFFF_FFFF);
                default: write_reg(CFG_POOL_BASE, $urandom);
            endcase
            write_reg(CFG_ELEM_LOG2, ($urandom_range(0, 4) == 0) ? $urandom_range(17, 31)
                                                                 : $urandom_range(0, 16));
            case ($urandom_range(0, 4))
                0:       write_reg(CFG_PER_CHUNK, 32'd0);
                1:       write_reg(CFG_PER_CHUNK, 32'd2047);
                2:       write_reg(CFG_PER_CHUNK, 32'd1024);
                default: write_reg(CFG_PER_CHUNK, $urandom_range(1, 64));
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_MAX_ELEM, 32'd0);
                1:       write_reg(CFG_MAX_ELEM, 32'd1);
                2:       write_reg(CFG_MAX_ELEM, 32'd1024);
                3:       write_reg(CFG_MAX_ELEM, 32'd2047);
                default: write_reg(CFG_MAX_ELEM, $urandom_range(1, 2047));
            endcase
            i_cfg_we <= 1'b0;
            idle_on = (ph % 3) != 2;
            repeat (30) begin
                pick_request(cmd, addr);
                send_item(cmd, addr, 1'b0, '0, pred);
            end
        end

        // drain the fresh supply up to the capacity cap, back to back
        settle_pool();
        write_reg(CFG_PER_CHUNK, 32'd2047);
        write_reg(CFG_MAX_ELEM, 32'd2047);
        i_cfg_we <= 1'b0;
        idle_on = 1'b0;
        full = 1'b0;
        for (k = 0; k < CAP + 64 && !full; k++) begin
            send_item(CMD_ALLOC, $urandom, 1'b0, '0, pred);
            full = (pred.st == ST_EXHAUSTED);
        end
        repeat (40) begin
            pick_request(cmd, addr);
            send_item(cmd, addr, 1'b0, '0, pred);
        end

        settle_pool();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d items and %0d register writes, ending with the pool filled to %0d.",
                 n_items, n_reg_writes, fresh_count);
        $display("Checked %0d results: %0d ok, %0d exhausted, %0d invalid frees.",
                 n_checked, n_ok, n_exhausted, n_invalid);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== chunked_buffer_pool_allocator_core.f =====
+incdir+rtl/core
rtl/core/cbpa_pkg.sv
rtl/core/cbpa_ram.sv
rtl/core/cbpa_fresh.sv
rtl/core/cbpa_addr.sv
rtl/core/chunked_buffer_pool_allocator_core.sv
tb/tb_top.sv
